// ===== hdl/tptlv_pkg.sv =====
// ----------------------------------------------------------------------------
// tptlv_pkg
// Shared types and constants for the transport parameter TLV parser.
// ----------------------------------------------------------------------------
package tptlv_pkg;

	localparam int MaxSeen   = 64;
	localparam int SeenIdxW  = $clog2(MaxSeen);
	localparam int SeenCntW  = $clog2(MaxSeen + 1);

	// result kinds
	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_NUM   = 2'd1;
	localparam logic [1:0] KIND_OTHER = 2'd2;
	localparam logic [1:0] KIND_END   = 2'd3;

	// input opcodes
	localparam logic OP_DATA = 1'b0;
	localparam logic OP_END  = 1'b1;

	// parse phase
	typedef enum logic [2:0] {
		PH_ID_START, PH_ID_CONT, PH_LEN_START, PH_LEN_CONT, PH_VALUE, PH_ERROR
	} phase_t;

	// sequencer state
	typedef enum logic [2:0] {
		ST_IDLE, ST_SEARCH, ST_EXEC, ST_OUT1, ST_OUT2
	} state_t;

	// parameter class
	typedef enum logic [2:0] {
		CL_CID, CL_TOKEN, CL_NUM, CL_MIGR, CL_PREF, CL_OTHER
	} class_t;

	// one result record
	typedef struct packed {
		logic        last;
		logic        failed;
		logic [7:0]  value_byte;
		logic [5:0]  byte_index;
		logic [61:0] value_length;
		logic [61:0] param_value;
		logic [61:0] prm_id;
		logic [1:0]  kind;
	} result_t;

	function automatic class_t classify(input logic [61:0] id);
		class_t c;
		c = CL_OTHER;
		if (id == 62'h00 || id == 62'h0f || id == 62'h10) c = CL_CID;
		else if (id == 62'h02) c = CL_TOKEN;
		else if (id == 62'h0c) c = CL_MIGR;
		else if (id == 62'h0d) c = CL_PREF;
		else if (id == 62'h01 || (id >= 62'h03 && id <= 62'h0b) || id == 62'h0e
			|| id == 62'h20) c = CL_NUM;
		return c;
	endfunction

	function automatic logic numeric_ok(input logic [61:0] id, input logic [61:0] v);
		logic ok;
		ok = 1'b1;
		case (id)
			62'h03: ok = (v >= 62'd1200) && (v <= 62'd65527);
			62'h08, 62'h09: ok = v <= (62'd1 << 60);
			62'h0a: ok = v <= 62'd20;
			62'h0b: ok = v < 62'd16384;
			62'h0e: ok = v >= 62'd2;
			default: ok = 1'b1;
		endcase
		return ok;
	endfunction

endpackage

// ===== hdl/transport_param_tlv_parser_unit.sv =====
// ----------------------------------------------------------------------------
// transport_param_tlv_parser_unit
// QUIC transport-parameter block decoder, one byte per request.
// ----------------------------------------------------------------------------
// A request is accepted, executed, then given an output slot. A byte that
// completes a parameter id first walks the seen-id memory through its single
// read port with one shared compare, one stored id at a time, before it is
// executed. Results go out through an output register, one a cycle while
// m_tready is high; m_tready low holds the current result. The next request
// is taken once the last result of this byte has left. An end-of-buffer
// request yields one end-status record and resets.
module transport_param_tlv_parser_unit
	import tptlv_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte[7:0]
	input  logic         s_tuser,   // opcode
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [207:0] m_tdata,   // id, param_value, value_length,
	                                // byte_index, value_byte, failed, pad
	output logic [1:0]   m_tuser,   // kind
	output logic         m_tlast    // last
);

	state_t            state_q, state_d;
	phase_t            phase_q;
	logic [61:0]       acc_q, cur_id_q, cur_len_q, left_q;
	logic [2:0]        vleft_q;
	logic [SeenCntW-1:0] seen_cnt_q, srch_q;
	logic              err_q;
	logic [7:0]        byte_q;
	logic              op_q;
	logic [61:0]       seen_mem [MaxSeen];
	logic [61:0]       rd_q;
	logic              dup_q;
	result_t           res1_q, res2_q;
	logic [1:0]        nres_q;
	logic              srch_start;
	result_t           cur_res;

	function automatic logic vdone(input logic [7:0] b);
		if (phase_q == PH_ID_START || phase_q == PH_LEN_START)
			return b[7:6] == 2'd0;
		return vleft_q == 3'd1;
	endfunction

	function automatic logic [61:0] nacc(input logic [7:0] b);
		if (phase_q == PH_ID_START || phase_q == PH_LEN_START)
			return {56'd0, b[5:0]};
		return {acc_q[53:0], b};
	endfunction

	// completing id byte with ids stored: walk the memory first
	assign srch_start = (s_tuser == OP_DATA) && (phase_q inside {PH_ID_START, PH_ID_CONT}) &&
		(seen_cnt_q != '0) && ((phase_q == PH_ID_START && s_tdata[7:6] == 2'd0) ||
		(phase_q == PH_ID_CONT && vleft_q == 3'd1));

	// next-state logic
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = srch_start ? ST_SEARCH : ST_EXEC;
			ST_SEARCH: if (srch_q == seen_cnt_q) state_d = ST_EXEC;
			ST_EXEC:   state_d = ST_OUT1;
			ST_OUT1: begin
				if (nres_q == 2'd0) state_d = ST_IDLE;
				else if (m_tready) state_d = (nres_q == 2'd2) ? ST_OUT2 : ST_IDLE;
			end
			ST_OUT2:   if (m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign s_tready = (state_q == ST_IDLE);

	// output register view
	always_comb begin
		cur_res = (state_q == ST_OUT2) ? res2_q : res1_q;
		m_tvalid = (state_q == ST_OUT1 && nres_q != 2'd0) || (state_q == ST_OUT2);
		m_tuser  = cur_res.kind;
		m_tlast  = cur_res.last;
		m_tdata  = {7'd0, cur_res.failed, cur_res.value_byte, cur_res.byte_index,
			cur_res.value_length, cur_res.param_value, cur_res.prm_id};
	end

	// seen-id memory, read one entry per search cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC && phase_q inside {PH_ID_START, PH_ID_CONT} &&
				!op_q && !dup_q && seen_cnt_q < SeenCntW'(MaxSeen) &&
				srch_q == seen_cnt_q && vdone(byte_q))
			seen_mem[seen_cnt_q[SeenIdxW-1:0]] <= nacc(byte_q);
		rd_q <= seen_mem[srch_q[SeenIdxW-1:0]];
	end

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		result_t r;
		class_t  cl;
		logic [61:0] v, pos, nl;
		logic        done;
		logic [1:0]  nr;
		if (!arst_n) begin
			phase_q <= PH_ID_START; err_q <= 1'b0;
			acc_q <= '0; cur_id_q <= '0; cur_len_q <= '0; left_q <= '0;
			vleft_q <= '0; seen_cnt_q <= '0; srch_q <= '0; dup_q <= 1'b0;
			nres_q <= '0; byte_q <= '0; op_q <= 1'b0;
			res1_q <= '0; res2_q <= '0;
		end else begin
			r = '0;
			case (state_q)
				ST_IDLE: if (s_tvalid) begin
					byte_q <= s_tdata; op_q <= s_tuser;
					srch_q <= '0; dup_q <= 1'b0;
				end
				ST_SEARCH: begin
					// one compare per cycle against the registered read
					if (srch_q != '0 && rd_q == nacc(byte_q)) dup_q <= 1'b1;
					if (srch_q != seen_cnt_q) srch_q <= srch_q + 1'b1;
				end
				ST_EXEC: begin
					nr = 2'd0;
					if (op_q == OP_END) begin
						r.kind = KIND_END;
						r.failed = err_q || phase_q != PH_ID_START;
						r.last = 1'b1;
						res1_q <= r; nr = 2'd1;
						phase_q <= PH_ID_START; err_q <= 1'b0; acc_q <= '0;
						cur_id_q <= '0; cur_len_q <= '0; left_q <= '0;
						vleft_q <= '0; seen_cnt_q <= '0;
					end else begin
						v = nacc(byte_q);
						done = vdone(byte_q);
						case (phase_q)
							PH_ID_START, PH_ID_CONT, PH_LEN_START, PH_LEN_CONT: begin
								acc_q <= v;
								vleft_q <= (phase_q == PH_ID_START ||
									phase_q == PH_LEN_START) ?
									3'((4'd1 << byte_q[7:6]) - 4'd1) : vleft_q - 3'd1;
								if (!done) begin
									phase_q <= (phase_q == PH_ID_START ||
										phase_q == PH_ID_CONT) ? PH_ID_CONT : PH_LEN_CONT;
								end else if (phase_q == PH_ID_START ||
										phase_q == PH_ID_CONT) begin
									cur_id_q <= v;
									if (dup_q || seen_cnt_q >= SeenCntW'(MaxSeen)) begin
										phase_q <= PH_ERROR; err_q <= 1'b1;
									end else begin
										seen_cnt_q <= seen_cnt_q + 1'b1;
										phase_q <= PH_LEN_START;
									end
								end else begin
									cl = classify(cur_id_q);
									cur_len_q <= v; left_q <= v;
									if ((cl == CL_CID && v > 62'd20) ||
										(cl == CL_TOKEN && v != 62'd16) ||
										(cl == CL_MIGR && v != 62'd0) ||
										(cl == CL_PREF && (v < 62'd42 || v > 62'd61)) ||
										(v == 62'd0 && cl == CL_NUM)) begin
										phase_q <= PH_ERROR; err_q <= 1'b1;
									end else if (v == 62'd0) begin
										phase_q <= PH_ID_START;
										r.kind = KIND_OTHER; r.prm_id = cur_id_q;
										r.last = 1'b1; res1_q <= r; nr = 2'd1;
									end else phase_q <= PH_VALUE;
								end
							end
							PH_VALUE: begin
								cl = classify(cur_id_q);
								pos = cur_len_q - left_q;
								nl = left_q - 62'd1;
								left_q <= nl;
								if (cl == CL_NUM) begin
									v = (pos == '0) ? {56'd0, byte_q[5:0]} :
										{acc_q[53:0], byte_q};
									acc_q <= v;
									if (pos == '0 && (62'd1 << byte_q[7:6]) != cur_len_q) begin
										phase_q <= PH_ERROR; err_q <= 1'b1;
									end else if (nl == '0) begin
										if (!numeric_ok(cur_id_q, v)) begin
											phase_q <= PH_ERROR; err_q <= 1'b1;
										end else begin
											phase_q <= PH_ID_START;
											r.kind = KIND_NUM; r.prm_id = cur_id_q;
											r.param_value = v; r.value_length = cur_len_q;
											r.last = 1'b1; res1_q <= r; nr = 2'd1;
										end
									end
								end else if (cl == CL_PREF && pos == 62'd24 &&
										(byte_q < 8'd1 || byte_q > 8'd20 ||
										cur_len_q != 62'd41 + {54'd0, byte_q})) begin
									phase_q <= PH_ERROR; err_q <= 1'b1;
								end else begin
									if (cl == CL_CID || cl == CL_TOKEN) begin
										r.kind = KIND_BYTE; r.prm_id = cur_id_q;
										r.value_length = cur_len_q;
										r.byte_index = pos[5:0]; r.value_byte = byte_q;
										r.last = (nl != '0);
										res1_q <= r; nr = 2'd1;
									end
									if (nl == '0) begin
										phase_q <= PH_ID_START;
										r = '0;
										r.kind = KIND_OTHER; r.prm_id = cur_id_q;
										r.value_length = cur_len_q; r.last = 1'b1;
										if (cl == CL_CID || cl == CL_TOKEN) begin
											res2_q <= r; nr = 2'd2;
										end else begin
											res1_q <= r; nr = 2'd1;
										end
									end
								end
							end
							default: ;
						endcase
					end
					nres_q <= nr;
				end
				default: ;
			endcase
		end
	end

	// checks
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready) else $error("ready while busy");
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_END) |-> m_tlast) else $error("end not last");
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_cnt_q <= SeenCntW'(MaxSeen)) else $error("seen count overflow");

endmodule

// ===== dv/tb_transport_param_tlv_parser_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_transport_param_tlv_parser_unit
// Feeds well-formed and damaged transport-parameter blocks byte by byte and
// compares every emitted record against a behavioral predictor of the parser.
// ----------------------------------------------------------------------------
module tb_transport_param_tlv_parser_unit;
	import tptlv_pkg::*;

	typedef struct {
		logic       op;
		logic [7:0] b;
	} req_t;

	typedef struct {
		logic [1:0]  kind;
		logic [61:0] id;
		logic [61:0] val;
		logic [61:0] len;
		logic [5:0]  idx;
		logic [7:0]  vbyte;
		logic        failed;
		logic        last;
	} rec_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [207:0] m_tdata;
	logic [1:0]   m_tuser;
	logic         m_tlast;

	transport_param_tlv_parser_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #1 clk = ~clk;

	req_t pending_bytes[$];
	rec_t expected_recs[$];
	int   errors = 0;
	int   recs_seen = 0;
	int   blocks_sent = 0;
	int   send_idle_pct = 0;
	int   recv_stall_pct = 0;
	longint cycles = 0;

	// predictor state
	phase_t      p_phase;
	logic [61:0] p_acc;
	int          p_vleft;
	logic [61:0] p_id;
	logic [61:0] p_len;
	logic [61:0] p_left;
	logic [61:0] p_seen[MaxSeen];
	int          p_seen_cnt;
	logic        p_err;

	task automatic parser_clear();
		p_phase = PH_ID_START;
		p_acc = '0;
		p_vleft = 0;
		p_id = '0;
		p_len = '0;
		p_left = '0;
		p_seen_cnt = 0;
		p_err = 1'b0;
	endtask

	function automatic class_t param_class(logic [61:0] id);
		if (id == 62'h00 || id == 62'h0f || id == 62'h10) return CL_CID;
		if (id == 62'h02) return CL_TOKEN;
		if (id == 62'h0c) return CL_MIGR;
		if (id == 62'h0d) return CL_PREF;
		if (id == 62'h01 || (id >= 62'h03 && id <= 62'h0b) || id == 62'h0e || id == 62'h20)
			return CL_NUM;
		return CL_OTHER;
	endfunction

	function automatic logic value_in_range(logic [61:0] id, logic [61:0] v);
		case (id)
			62'h03: return v >= 1200 && v <= 65527;
			62'h08, 62'h09: return v <= (62'd1 << 60);
			62'h0a: return v <= 20;
			62'h0b: return v < 16384;
			62'h0e: return v >= 2;
			default: return 1'b1;
		endcase
	endfunction

	task automatic push_rec(logic [1:0] k, logic [61:0] id, logic [61:0] v, logic [61:0] l,
			logic [5:0] ix, logic [7:0] vb, logic f, inout rec_t q[$]);
		rec_t r;
		r = '{k, id, v, l, ix, vb, f, 1'b0};
		q.push_back(r);
	endtask

	task automatic parser_fail();
		p_phase = PH_ERROR;
		p_err = 1'b1;
	endtask

	// advance varint reader, return 1 when complete
	function automatic logic varint_step(logic [7:0] b, logic first);
		if (first) begin
			p_acc = {56'd0, b[5:0]};
			p_vleft = (1 << b[7:6]) - 1;
		end else begin
			p_acc = {p_acc[53:0], b};
			p_vleft--;
		end
		return p_vleft == 0;
	endfunction

	task automatic predict_parse(req_t rq);
		rec_t   o[$];
		class_t cl;
		logic [61:0] pos;
		logic   dup;
		if (rq.op == OP_END) begin
			push_rec(KIND_END, '0, '0, '0, '0, '0, p_err || p_phase != PH_ID_START, o);
			parser_clear();
		end else begin
			case (p_phase)
				PH_ID_START, PH_ID_CONT: begin
					if (varint_step(rq.b, p_phase == PH_ID_START)) begin
						p_id = p_acc;
						dup = 1'b0;
						for (int i = 0; i < p_seen_cnt; i++)
							if (p_seen[i] == p_id) dup = 1'b1;
						if (dup || p_seen_cnt >= MaxSeen) parser_fail();
						else begin
							p_seen[p_seen_cnt] = p_id;
							p_seen_cnt++;
							p_phase = PH_LEN_START;
						end
					end else p_phase = PH_ID_CONT;
				end
				PH_LEN_START, PH_LEN_CONT: begin
					if (varint_step(rq.b, p_phase == PH_LEN_START)) begin
						cl = param_class(p_id);
						p_len = p_acc;
						p_left = p_acc;
						if ((cl == CL_CID && p_len > 20) || (cl == CL_TOKEN && p_len != 16) ||
								(cl == CL_MIGR && p_len != 0) ||
								(cl == CL_PREF && (p_len < 42 || p_len > 61)) ||
								(cl == CL_NUM && p_len == 0))
							parser_fail();
						else if (p_len == 0) begin
							p_phase = PH_ID_START;
							push_rec(KIND_OTHER, p_id, '0, '0, '0, '0, 1'b0, o);
						end else p_phase = PH_VALUE;
					end else p_phase = PH_LEN_CONT;
				end
				PH_VALUE: begin
					cl = param_class(p_id);
					pos = p_len - p_left;
					p_left--;
					if (cl == CL_CID || cl == CL_TOKEN)
						push_rec(KIND_BYTE, p_id, '0, p_len, pos[5:0], rq.b, 1'b0, o);
					if (cl == CL_NUM) begin
						if (pos == 0 && (62'd1 << rq.b[7:6]) != p_len) parser_fail();
						else begin
							if (pos == 0) p_acc = {56'd0, rq.b[5:0]};
							else p_acc = {p_acc[53:0], rq.b};
							if (p_left == 0) begin
								p_phase = PH_ID_START;
								if (!value_in_range(p_id, p_acc)) parser_fail();
								else push_rec(KIND_NUM, p_id, p_acc, p_len, '0, '0, 1'b0, o);
							end
						end
					end else if (cl == CL_PREF && pos == 24 &&
							(rq.b < 1 || rq.b > 20 || p_len != 41 + rq.b)) begin
						parser_fail();
					end else if (p_left == 0) begin
						p_phase = PH_ID_START;
						push_rec(KIND_OTHER, p_id, '0, p_len, '0, '0, 1'b0, o);
					end
				end
				default: ;
			endcase
		end
		if (o.size() > 0) o[o.size()-1].last = 1'b1;
		foreach (o[i]) expected_recs.push_back(o[i]);
	endtask

	// ---------------------------------------------------------------- stimulus
	task automatic put_byte(logic [7:0] b);
		pending_bytes.push_back('{OP_DATA, b});
	endtask

	task automatic put_end();
		pending_bytes.push_back('{OP_END, 8'($urandom_range(255, 0))});
		blocks_sent++;
	endtask

	// varint of v with the given size code (0..3), v must fit
	task automatic put_varint(logic [61:0] v, int code);
		int n;
		n = 1 << code;
		for (int i = n - 1; i >= 0; i--) begin
			if (i == n - 1) put_byte({2'(code), 6'(v >> (8 * i))});
			else put_byte(8'(v >> (8 * i)));
		end
	endtask

	function automatic int min_code(logic [61:0] v);
		if (v < 64) return 0;
		if (v < 16384) return 1;
		if (v < 62'd1 << 30) return 2;
		return 3;
	endfunction

	function automatic int rnd_code(logic [61:0] v);
		int c;
		c = min_code(v);
		if ($urandom_range(3, 0) == 0) c = $urandom_range(3, c);
		return c;
	endfunction

	function automatic logic [61:0] rand62();
		logic [61:0] v;
		v = 62'({$urandom(), $urandom()});
		case ($urandom_range(4, 0))
			0: v = v & 62'h3f;
			1: v = v & 62'h3fff;
			2: v = v & 62'h3fff_ffff;
			default: ;
		endcase
		return v;
	endfunction

	function automatic logic [61:0] numeric_value(logic [61:0] id);
		if ($urandom_range(4, 0) == 0) return rand62();
		case (id)
			62'h03: return 62'($urandom_range(65527, 1200));
			62'h08, 62'h09: return $urandom_range(1, 0) ? (62'd1 << 60) : rand62() >> 2;
			62'h0a: return 62'($urandom_range(20, 0));
			62'h0b: return 62'($urandom_range(16383, 0));
			62'h0e: return 62'($urandom_range(100, 2));
			default: return rand62();
		endcase
	endfunction

	// one parameter entry, mostly legal
	task automatic put_entry(logic [61:0] id, logic sloppy);
		class_t cl;
		int len, code, cidl;
		logic [61:0] v;
		cl = param_class(id);
		put_varint(id, rnd_code(id));
		case (cl)
			CL_CID: len = sloppy ? $urandom_range(24, 0) : $urandom_range(20, 0);
			CL_TOKEN: len = sloppy ? $urandom_range(18, 14) : 16;
			CL_MIGR: len = sloppy ? $urandom_range(1, 0) : 0;
			CL_PREF: begin
				cidl = sloppy ? $urandom_range(22, 0) : $urandom_range(20, 1);
				len = sloppy && $urandom_range(1, 0) ? $urandom_range(62, 41) : 41 + cidl;
			end
			CL_NUM: begin
				v = numeric_value(id);
				code = rnd_code(v);
				len = 1 << code;
				if (sloppy && $urandom_range(2, 0) == 0) len = $urandom_range(8, 0);
			end
			default: len = $urandom_range(12, 0);
		endcase
		put_varint(62'(len), rnd_code(62'(len)));
		if (cl == CL_NUM && len == (1 << code)) put_varint(v, code);
		else begin
			for (int i = 0; i < len; i++)
				if (cl == CL_PREF && i == 24) put_byte(8'(cidl));
				else put_byte(8'($urandom_range(255, 0)));
		end
	endtask

	function automatic logic [61:0] pick_id();
		case ($urandom_range(9, 0))
			0: return 62'({$urandom(), $urandom()});
			1: return 62'($urandom_range(200, 'h21));
			2: return 62'h20;
			default: return 62'($urandom_range(16, 0));
		endcase
	endfunction

	task automatic put_block(int entries, logic sloppy);
		logic [61:0] ids[$];
		logic [61:0] id;
		for (int e = 0; e < entries; e++) begin
			id = pick_id();
			if (ids.size() > 0 && $urandom_range(15, 0) == 0) id = ids[$urandom_range(ids.size()-1, 0)];
			else while (id inside {ids}) id = id + 62'h41;
			ids.push_back(id);
			put_entry(id, sloppy);
		end
		// occasional truncation or noise
		if (sloppy && $urandom_range(3, 0) == 0)
			repeat ($urandom_range(3, 1)) put_byte(8'($urandom_range(255, 0)));
		put_end();
	endtask

	task automatic run_phase(int n_items, int idle, int stall);
		int target;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		target = pending_bytes.size() + n_items;
		while (pending_bytes.size() < target)
			put_block($urandom_range(6, 1), $urandom_range(3, 0) == 0);
		wait (pending_bytes.size() == 0 && !s_tvalid && expected_recs.size() == 0);
	endtask

	// ---------------------------------------------------------------- driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (!s_tvalid || s_tready) begin
				if (pending_bytes.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					predict_parse(pending_bytes[0]);
					s_tuser  <= pending_bytes[0].op;
					s_tdata  <= pending_bytes[0].b;
					s_tvalid <= 1'b1;
					void'(pending_bytes.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= $urandom_range(99, 0) >= recv_stall_pct;
		end
	end

	// ---------------------------------------------------------------- monitor
	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch rec %0d %s got %h want %h", recs_seen, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		rec_t w;
		cycles++;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_recs.size() == 0) begin
				report_mismatch("unexpected record kind", m_tuser, '0);
			end else begin
				w = expected_recs.pop_front();
				if (m_tuser != w.kind) report_mismatch("kind", m_tuser, w.kind);
				if (m_tdata[61:0] != w.id) report_mismatch("id", m_tdata[61:0], w.id);
				if (m_tdata[123:62] != w.val) report_mismatch("param_value", m_tdata[123:62], w.val);
				if (m_tdata[185:124] != w.len)
					report_mismatch("value_length", m_tdata[185:124], w.len);
				if (m_tdata[191:186] != w.idx) report_mismatch("byte_index", m_tdata[191:186], w.idx);
				if (m_tdata[199:192] != w.vbyte)
					report_mismatch("value_byte", m_tdata[199:192], w.vbyte);
				if (m_tdata[200] != w.failed) report_mismatch("failed", m_tdata[200], w.failed);
				if (m_tlast != w.last) report_mismatch("last", m_tlast, w.last);
			end
			recs_seen++;
		end
	end

	// ---------------------------------------------------------------- sequence
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		parser_clear();
		// directed: extremes, CID, numeric, migration and other classes, special cases
		put_varint(62'h00, 0); put_varint(20, 0);
		for (int i = 0; i < 20; i++) put_byte(8'(i * 13));
		put_varint(62'h03, 3); put_varint(2, 0); put_varint(1200, 1);
		put_varint(62'h0c, 1); put_varint(0, 0);
		put_varint(62'h3fff_ffff_ffff_ffff, 3); put_varint(0, 0);
		put_end();
		put_varint(62'h01, 0); put_varint(0, 0); put_end();        // zero-length numeric
		put_varint(62'h05, 0); put_varint(2, 0); put_byte(8'hff); put_end(); // bad prefix
		put_varint(62'h07, 0); put_end();                          // truncated
		put_varint(62'h21, 0); put_varint(0, 0); put_varint(62'h21, 0); put_end(); // dup
		put_byte(8'hff); put_byte(8'h00); put_end();
		put_end();
		run_phase(0, 0, 0);
		// too many entries
		for (int e = 0; e <= MaxSeen; e++) begin
			put_varint(62'h40 + e, 1); put_varint(0, 0);
		end
		put_end();
		run_phase(0, 0, 0);
		run_phase(160, 0, 0);
		run_phase(160, 64, 0);
		run_phase(160, 0, 64);
		run_phase(160, 27, 27);
		repeat (20) @(posedge clk);
		$display("%0d blocks, %0d records checked over four idle/stall mixes",
			blocks_sent, recs_seen);
		if (errors == 0 && expected_recs.size() == 0) $display("[transport_param_tlv_parser_unit] OK");
		else $display("[transport_param_tlv_parser_unit] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (cycles == 400000) begin
			$display("[transport_param_tlv_parser_unit] ERROR");
			$finish;
		end
	end

endmodule
